// ----- rtl/dual_encoder_position_speed_top_macros.svh -----
// Assertion macros for the encoder position/speed block.
// Each macro samples on clk and is disabled while rst is high.
`ifndef DUAL_ENCODER_POSITION_SPEED_TOP_MACROS_SVH
`define DUAL_ENCODER_POSITION_SPEED_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DEP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define DEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DEP_ASSERT_NOW(label, ante, cons)
`define DEP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/dep_pkg.sv -----
package dep_pkg;

  typedef logic signed [31:0] count_t;
  typedef logic [4:0]         shift_t;

  // control from the tick stage to each wheel datapath
  typedef struct packed {
    logic fire;     // a beat leaves the input register this cycle
    logic capture;  // first beat after reset: only latch the reading
    logic clear;    // zero position before adding delta
  } wheel_ctrl_t;

  localparam int     TICKS_PER_SECOND   = 1000;
  localparam shift_t FILTER_SHIFT_RESET = 5'd3;

endpackage

// ----- rtl/dep_if.sv -----
interface dep_in_if;
  logic            valid;
  logic            ready;
  dep_pkg::count_t left_count;
  dep_pkg::count_t right_count;
  logic            clear_left_position;
  logic            clear_right_position;

  modport source (
    output valid, left_count, right_count, clear_left_position, clear_right_position,
    input  ready
  );
  modport sink (
    input  valid, left_count, right_count, clear_left_position, clear_right_position,
    output ready
  );
endinterface

interface dep_out_if;
  logic            valid;
  logic            ready;
  dep_pkg::count_t left_delta;
  dep_pkg::count_t right_delta;
  dep_pkg::count_t left_position;
  dep_pkg::count_t right_position;
  dep_pkg::count_t left_speed;
  dep_pkg::count_t right_speed;

  modport source (
    output valid, left_delta, right_delta, left_position, right_position,
           left_speed, right_speed,
    input  ready
  );
  modport sink (
    input  valid, left_delta, right_delta, left_position, right_position,
           left_speed, right_speed,
    output ready
  );
endinterface

interface dep_cfg_if;
  logic            valid;
  logic            ready;
  dep_pkg::shift_t filter_shift;

  modport source (output valid, filter_shift, input ready);
  modport sink (input valid, filter_shift, output ready);
endinterface

// ----- rtl/dep_wheel.sv -----
module dep_wheel #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dep_pkg::wheel_ctrl_t ctrl,
  input  dep_pkg::shift_t      shift,
  input  dep_pkg::count_t      reading,
  output dep_pkg::count_t      delta,
  output dep_pkg::count_t      position,
  output dep_pkg::count_t      speed
);

  logic [COUNT_WIDTH-1:0] last_reading;
  dep_pkg::count_t        pos_total;
  dep_pkg::count_t        filt_speed;

  logic [COUNT_WIDTH-1:0] diff;
  dep_pkg::count_t        step_delta;
  dep_pkg::count_t        pos_next;
  logic signed [42:0]     product;
  dep_pkg::count_t        raw_speed;
  logic signed [32:0]     err;
  logic [32:0]            mag;
  logic [32:0]            mag_sh;
  dep_pkg::count_t        filt_next;

  always_comb begin
    diff       = reading[COUNT_WIDTH-1:0] - last_reading;
    step_delta = 32'(signed'(diff));
    pos_next   = (ctrl.clear ? 32'sd0 : pos_total) + step_delta;

    product = 43'(step_delta) * 43'(dep_pkg::TICKS_PER_SECOND);
    if (product > 43'sh0_7FFF_FFFF) begin
      raw_speed = 32'sh7FFF_FFFF;
    end else if (product < -43'sh0_8000_0000) begin
      raw_speed = 32'sh8000_0000;
    end else begin
      raw_speed = product[31:0];
    end

    // symmetric shift: magnitude shifted, sign restored
    err    = 33'(raw_speed) - 33'(filt_speed);
    mag    = err[32] ? 33'(-err) : 33'(err);
    mag_sh = mag >> shift;
    if (err[32]) begin
      filt_next = filt_speed - mag_sh[31:0];
    end else begin
      filt_next = filt_speed + mag_sh[31:0];
    end
  end

  assign delta    = ctrl.capture ? 32'sd0 : step_delta;
  assign position = ctrl.capture ? pos_total : pos_next;
  assign speed    = ctrl.capture ? filt_speed : filt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_reading <= '0;
      pos_total    <= '0;
      filt_speed   <= '0;
    end else if (ctrl.fire) begin
      last_reading <= reading[COUNT_WIDTH-1:0];
      if (!ctrl.capture) begin
        pos_total  <= pos_next;
        filt_speed <= filt_next;
      end
    end
  end

endmodule

// ----- rtl/dual_encoder_position_speed_top.sv -----
// Dual wheel encoder position and speed tracker.
// tick (sink): one beat per control tick with both raw counter readings and
//   one position-clear flag per wheel.
// result (source): one beat per tick beat with per-wheel delta, wrapped
//   position and IIR-filtered speed (delta * 1000, saturated, smoothed by
//   1/2^filter_shift).
// cfg (sink): writes filter_shift; always ready, write only while idle.
// Path: a tick beat passes the input register, then the result register;
//   the wheel update between those two registers is one subtract,
//   constant multiply, saturate and shift.
//   Throughput: one beat per cycle while result is not held (see Stall).
// Reset: wheel state clears, filter_shift returns to 3, and the block is
//   unprimed: the first tick after reset only latches the readings and
//   reports zero delta with unchanged position and speed.
// Stall: while result is held, the result register keeps its beat; the input
//   register still takes one more tick beat, then tick.ready drops.
`include "dual_encoder_position_speed_top_macros.svh"

module dual_encoder_position_speed_top #(
  parameter int COUNT_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  dep_in_if.sink     tick,
  dep_out_if.source  result,
  dep_cfg_if.sink    cfg
);

  // config register
  dep_pkg::shift_t filter_shift;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_shift <= dep_pkg::FILTER_SHIFT_RESET;
    end else if (cfg.valid) begin
      filter_shift <= cfg.filter_shift;
    end
  end

  // input register
  logic            in_valid;
  dep_pkg::count_t in_left_count;
  dep_pkg::count_t in_right_count;
  logic            in_clear_left;
  logic            in_clear_right;

  logic advance;   // result register can load
  logic fire;      // input beat moves into the wheel update
  logic primed;

  assign advance    = !result.valid || result.ready;
  assign fire       = in_valid && advance;
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_left_count  <= tick.left_count;
      in_right_count <= tick.right_count;
      in_clear_left  <= tick.clear_left_position;
      in_clear_right <= tick.clear_right_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (fire) begin
      primed <= 1'b1;
    end
  end

  // per-wheel datapaths
  dep_pkg::wheel_ctrl_t left_ctrl;
  dep_pkg::wheel_ctrl_t right_ctrl;
  dep_pkg::count_t      left_delta, right_delta;
  dep_pkg::count_t      left_position, right_position;
  dep_pkg::count_t      left_speed, right_speed;

  always_comb begin
    left_ctrl.fire     = fire;
    left_ctrl.capture  = !primed;
    left_ctrl.clear    = in_clear_left;
    right_ctrl.fire    = fire;
    right_ctrl.capture = !primed;
    right_ctrl.clear   = in_clear_right;
  end

  dep_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (left_ctrl),
    .shift    (filter_shift),
    .reading  (in_left_count),
    .delta    (left_delta),
    .position (left_position),
    .speed    (left_speed)
  );

  dep_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (right_ctrl),
    .shift    (filter_shift),
    .reading  (in_right_count),
    .delta    (right_delta),
    .position (right_position),
    .speed    (right_speed)
  );

  // result register
  logic            out_valid;
  dep_pkg::count_t out_left_delta, out_right_delta;
  dep_pkg::count_t out_left_position, out_right_position;
  dep_pkg::count_t out_left_speed, out_right_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_left_delta     <= left_delta;
      out_right_delta    <= right_delta;
      out_left_position  <= left_position;
      out_right_position <= right_position;
      out_left_speed     <= left_speed;
      out_right_speed    <= right_speed;
    end
  end

  assign result.valid          = out_valid;
  assign result.left_delta     = out_left_delta;
  assign result.right_delta    = out_right_delta;
  assign result.left_position  = out_left_position;
  assign result.right_position = out_right_position;
  assign result.left_speed     = out_left_speed;
  assign result.right_speed    = out_right_speed;

  // checks
  `DEP_ASSERT_NEXT(a_fire_gives_result, fire, result.valid)
  `DEP_ASSERT_NEXT(a_primed_sticky, primed, primed)
  `DEP_ASSERT_NEXT(a_first_beat_zero_delta, fire && !primed,
                   result.left_delta == 32'sd0 && result.right_delta == 32'sd0)
  `DEP_ASSERT_NEXT(a_accept_fills_input, tick.valid && tick.ready, in_valid)
  `DEP_ASSERT_NOW(a_stall_blocks_input, in_valid && result.valid && !result.ready,
                  !fire)

endmodule

// ----- dv/tb_dual_encoder_position_speed_top.sv -----
module tb_dual_encoder_position_speed_top;

  // Block configuration under test and run pacing.
  localparam int COUNT_WIDTH    = 32;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on any channel
  localparam int HOLD_CYCLES    = 80;    // long receiver hold-off for pressure
  localparam int SETTLE_CYCLES  = 6;     // > two-register pipeline latency

  localparam longint SPEED_MAX = 64'sd2147483647;
  localparam longint SPEED_MIN = -64'sd2147483647 - 64'sd1;

  // One control tick as the sender sees it.
  typedef struct packed {
    dep_pkg::count_t left_count;
    dep_pkg::count_t right_count;
    logic            clear_left;
    logic            clear_right;
  } tick_beat_t;

  // One result beat, field for field as the block reports it.
  typedef struct packed {
    dep_pkg::count_t left_delta;
    dep_pkg::count_t right_delta;
    dep_pkg::count_t left_position;
    dep_pkg::count_t right_position;
    dep_pkg::count_t left_speed;
    dep_pkg::count_t right_speed;
  } wheel_report_t;

  logic clk = 1'b0;
  logic rst;

  dep_in_if  tick_if ();
  dep_out_if res_if ();
  dep_cfg_if cfg_if ();

  dual_encoder_position_speed_top #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  always #4 clk = ~clk;

  // Shadow of the block state, advanced once per accepted tick beat.
  dep_pkg::count_t last_count [2];
  dep_pkg::count_t position_sum [2];
  dep_pkg::count_t speed_filt [2];
  logic            primed;
  dep_pkg::shift_t shift_shadow;

  // Reports still owed by the block, oldest first.
  wheel_report_t pending_reports [$];

  int mismatch_cnt   = 0;
  int send_idle_pct  = 0;   // owned by the stimulus process
  int recv_stall_pct = 0;   // written by NBA, read by the receiver process
  int hold_req       = 0;   // bumped to ask the receiver for a long hold-off
  int hold_ack       = 0;
  int hold_left      = 0;
  int stuck_cycles   = 0;

  // ---------------------------------------------------------------------
  // Wheel math
  // ---------------------------------------------------------------------

  // One wheel, one tick: wrapping delta at COUNT_WIDTH, position accumulate
  // with optional clear, delta*1000 saturated, then the symmetric IIR step.
  function automatic dep_pkg::count_t step_wheel(int w, dep_pkg::count_t raw,
                                                 logic clr);
    logic [COUNT_WIDTH-1:0] diff_narrow;
    dep_pkg::count_t delta;
    longint raw_speed;
    longint gap;
    diff_narrow = raw[COUNT_WIDTH-1:0] - last_count[w][COUNT_WIDTH-1:0];
    delta = dep_pkg::count_t'($signed(diff_narrow));
    last_count[w] = raw;
    if (clr) begin
      position_sum[w] = '0;
    end
    position_sum[w] = position_sum[w] + delta;
    raw_speed = longint'(delta) * dep_pkg::TICKS_PER_SECOND;
    if (raw_speed > SPEED_MAX) begin
      raw_speed = SPEED_MAX;
    end
    if (raw_speed < SPEED_MIN) begin
      raw_speed = SPEED_MIN;
    end
    // exact 33+ bit difference; negative side shifts the magnitude so the
    // step rounds toward zero in both directions
    gap = raw_speed - longint'(speed_filt[w]);
    if (gap >= 0) begin
      speed_filt[w] = dep_pkg::count_t'(longint'(speed_filt[w]) + (gap >>> shift_shadow));
    end else begin
      speed_filt[w] = dep_pkg::count_t'(longint'(speed_filt[w]) - ((-gap) >>> shift_shadow));
    end
    return delta;
  endfunction

  // Expected report for one accepted tick. The first tick after reset only
  // latches the readings: clears ignored, zero deltas, state unchanged.
  function automatic wheel_report_t predict_tick(tick_beat_t t);
    wheel_report_t r;
    r = '0;
    if (!primed) begin
      last_count[0] = t.left_count;
      last_count[1] = t.right_count;
      primed = 1'b1;
    end else begin
      r.left_delta  = step_wheel(0, t.left_count, t.clear_left);
      r.right_delta = step_wheel(1, t.right_count, t.clear_right);
    end
    r.left_position  = position_sum[0];
    r.right_position = position_sum[1];
    r.left_speed     = speed_filt[0];
    r.right_speed    = speed_filt[1];
    return r;
  endfunction

  // Next counter reading for random traffic: mostly encoder-like small
  // steps, plus full-range values, readings near the signed boundary and
  // jumps big enough to saturate the speed.
  function automatic dep_pkg::count_t pick_count(dep_pkg::count_t prev);
    int unsigned sel;
    dep_pkg::count_t step;
    sel = $urandom_range(99);
    if (sel < 45) begin
      step = dep_pkg::count_t'($urandom_range(600)) - 32'sd300;
    end else if (sel < 60) begin
      step = dep_pkg::count_t'($urandom) >>> 11;
    end else if (sel < 75) begin
      return dep_pkg::count_t'($urandom);
    end else if (sel < 85) begin
      step = dep_pkg::count_t'($urandom_range(64));
      case ($urandom_range(3))
        0: return 32'sh7FFF_FFFF - step;
        1: return dep_pkg::count_t'(32'h8000_0000) + step;
        2: return step;
        default: return -step;
      endcase
    end else begin
      step = dep_pkg::count_t'($urandom_range(32'h7FFF_FFFF, 2147484));
      if ($urandom_range(1)) begin
        step = -step;
      end
    end
    return prev + step;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------

  // Offer one tick beat; valid stays up afterwards so back-to-back beats
  // never see a low/high pair in one step. Prediction happens at the
  // accepting edge.
  task automatic send_tick(input dep_pkg::count_t lc, input dep_pkg::count_t rc,
                           input logic cl, input logic cr);
    tick_beat_t t;
    t.left_count  = lc;
    t.right_count = rc;
    t.clear_left  = cl;
    t.clear_right = cr;
    while ($urandom_range(99) < send_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk);
    end
    tick_if.valid                <= 1'b1;
    tick_if.left_count           <= lc;
    tick_if.right_count          <= rc;
    tick_if.clear_left_position  <= cl;
    tick_if.clear_right_position <= cr;
    @(posedge clk);
    while (!tick_if.ready) begin
      @(posedge clk);
    end
    pending_reports.push_back(predict_tick(t));
  endtask

  // Drop valid, wait out every owed report, then let the pipeline settle.
  task automatic quiesce();
    tick_if.valid <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // filter_shift only changes while the block is empty.
  task automatic write_filter_shift(input dep_pkg::shift_t value);
    quiesce();
    cfg_if.valid        <= 1'b1;
    cfg_if.filter_shift <= value;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
    cfg_if.valid <= 1'b0;
    shift_shadow = value;
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= stall_pct;
  endtask

  task automatic send_random_ticks(input int n);
    repeat (n) begin
      send_tick(pick_count(last_count[0]), pick_count(last_count[1]),
                $urandom_range(9) == 0, $urandom_range(9) == 0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset shift (3). First beat only captures; its clear flags must be
  // ignored. Second beat crosses the signed wrap of the left counter.
  task automatic test_first_tick();
    set_idling(0, 0);
    send_tick(dep_pkg::count_t'(32'h7FFF_FFF0), -32'sd5, 1'b1, 1'b1);
    send_tick(dep_pkg::count_t'(32'h7FFF_FFF0) + 32'sd100, -32'sd105, 1'b0, 1'b0);
    send_tick(last_count[0], last_count[1], 1'b0, 1'b0);
  endtask

  // Shift 0: filtered speed equals raw speed, so saturation shows directly.
  // Deltas at both extremes and on both sides of the saturation threshold.
  task automatic test_speed_saturation();
    write_filter_shift(5'd0);
    send_tick(last_count[0] + 32'sh7FFF_FFFF,
              last_count[1] + dep_pkg::count_t'(32'h8000_0000), 1'b0, 1'b0);
    send_tick(last_count[0] + 32'sd2147483, last_count[1] - 32'sd2147484,
              1'b0, 1'b0);
    send_tick(last_count[0] + 32'sd2147484, last_count[1] - 32'sd2147483,
              1'b0, 1'b0);
    send_tick('0, -32'sd1, 1'b1, 1'b0);
    send_tick(-32'sd1, '0, 1'b0, 1'b1);
    send_tick(last_count[0], last_count[1], 1'b1, 1'b1);
  endtask

  // Big same-sign deltas push the positions through the 32-bit wrap;
  // a clear on one wheel only must not disturb the other.
  task automatic test_position_wrap();
    send_tick(last_count[0] + 32'sh7FFF_FFFF, last_count[1] - 32'sh7FFF_FFFF,
              1'b1, 1'b1);
    send_tick(last_count[0] + 32'sh7FFF_FFFF, last_count[1] - 32'sh7FFF_FFFF,
              1'b0, 1'b0);
    send_tick(last_count[0] + 32'sh7FFF_FFFF, last_count[1] - 32'sh7FFF_FFFF,
              1'b0, 1'b0);
    send_tick(last_count[0] + 32'sd5, last_count[1] + 32'sd7, 1'b1, 1'b0);
  endtask

  // Shift 31: only a full-scale swing moves the filter. Shift 2 with odd
  // negative differences checks rounding toward zero on the negative side.
  task automatic test_filter_rounding();
    write_filter_shift(5'd31);
    send_tick(last_count[0] + 32'sh7FFF_FFFF, last_count[1] + 32'sd3, 1'b0, 1'b0);
    send_tick(last_count[0] + dep_pkg::count_t'(32'h8000_0000), last_count[1] - 32'sd3,
              1'b0, 1'b0);
    send_tick(last_count[0] + 32'sh7FFF_FFFF, last_count[1], 1'b0, 1'b0);
    write_filter_shift(5'd2);
    send_tick(last_count[0] - 32'sd1, last_count[1] - 32'sd3, 1'b0, 1'b0);
    send_tick(last_count[0] - 32'sd3, last_count[1] + 32'sd1, 1'b0, 1'b0);
    send_tick(last_count[0] + 32'sd1, last_count[1] - 32'sd7, 1'b0, 1'b0);
    send_tick(last_count[0] - 32'sd7, last_count[1], 1'b0, 1'b0);
    send_tick(last_count[0], last_count[1] - 32'sd1, 1'b0, 1'b0);
  endtask

  task automatic test_random_streaming();
    write_filter_shift(dep_pkg::shift_t'($urandom_range(8, 1)));
    set_idling(0, 0);
    send_random_ticks(90);
  endtask

  task automatic test_random_sender_gaps();
    write_filter_shift(5'd0);
    set_idling(62, 0);
    send_random_ticks(70);
  endtask

  task automatic test_random_receiver_stalls();
    write_filter_shift(5'd31);
    set_idling(0, 62);
    send_random_ticks(70);
  endtask

  task automatic test_random_both_idle();
    write_filter_shift(dep_pkg::shift_t'($urandom));
    set_idling(22, 22);
    send_random_ticks(70);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering:
  // the result register and input register fill and tick.ready must drop.
  task automatic test_backpressure();
    write_filter_shift(5'd5);
    set_idling(0, 0);
    hold_req <= hold_req + 1;
    send_random_ticks(40);
    hold_req <= hold_req + 1;
    send_random_ticks(40);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off counted here
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input dep_pkg::count_t got,
                             input dep_pkg::count_t want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic check_report();
    wheel_report_t want;
    if (pending_reports.size() == 0) begin
      report_mismatch("result beat with no tick outstanding");
      return;
    end
    want = pending_reports.pop_front();
    check_field("left_delta", res_if.left_delta, want.left_delta);
    check_field("right_delta", res_if.right_delta, want.right_delta);
    check_field("left_position", res_if.left_position, want.left_position);
    check_field("right_position", res_if.right_position, want.right_position);
    check_field("left_speed", res_if.left_speed, want.left_speed);
    check_field("right_speed", res_if.right_speed, want.right_speed);
  endtask

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      check_report();
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst                          = 1'b1;
    tick_if.valid                = 1'b0;
    tick_if.left_count           = '0;
    tick_if.right_count          = '0;
    tick_if.clear_left_position  = 1'b0;
    tick_if.clear_right_position = 1'b0;
    cfg_if.valid                 = 1'b0;
    cfg_if.filter_shift          = '0;
    for (int w = 0; w < 2; w++) begin
      last_count[w]   = '0;
      position_sum[w] = '0;
      speed_filt[w]   = '0;
    end
    primed       = 1'b0;
    shift_shadow = dep_pkg::FILTER_SHIFT_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_tick();
    test_speed_saturation();
    test_position_wrap();
    test_filter_rounding();
    test_random_streaming();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();
    test_backpressure();

    set_idling(0, 0);
    quiesce();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
